FILE: hdl/tslc_pkg.sv
// Shared types and constants of the tile slot cache.
package tslc_pkg;

    localparam int LOGICAL_TILES = 1024;
    localparam int CACHE_SLOTS   = 256;
    localparam int MAP_WIDTH     = 32;

    localparam int TILE_W  = $clog2(LOGICAL_TILES);
    localparam int SLOT_W  = $clog2(CACHE_SLOTS);
    localparam int FILL_W  = SLOT_W + 1;
    localparam int TICK_W  = 32;
    localparam int HALF_W  = 16;
    localparam int INDEX_W = 10;
    localparam int SUB_SHIFT = 2;

    typedef struct packed {
        logic [9:0]  tile_id;
        logic [4:0]  col;
        logic [4:0]  row;
        logic [31:0] now_tick;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [7:0]  slot;
        logic [9:0]  base_tile;
        logic        evicted;
        logic [9:0]  evicted_tile;
        logic [9:0]  upper_index;
        logic [9:0]  lower_index;
        logic [31:0] upper_word;
        logic [31:0] lower_word;
    } t_res;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_map_entry;

    typedef struct packed {
        logic [TILE_W-1:0] owner;
        logic [TICK_W-1:0] seen;
    } t_slot_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot_entry       data;
    } t_slot_wr;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_scan_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EVICT,
        S_FILL
    } t_state;

endpackage

FILE: hdl/tslc_map_store.sv
// Tile-to-slot map memory with one read and one write port.
module tslc_map_store
    import tslc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [TILE_W-1:0] i_raddr,
    input  logic              i_we,
    input  logic [TILE_W-1:0] i_waddr,
    input  t_map_entry        i_wdata,
    output t_map_entry        o_rdata
);

    t_map_entry r_mem [LOGICAL_TILES];
    t_map_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tslc_slot_store.sv
// Slot memory of owners and last-seen ticks with the oldest-slot scan.
module tslc_slot_store
    import tslc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_wr          i_wr,
    input  t_scan_ctl         i_scan,
    input  logic [TICK_W-1:0] i_now,
    output logic [SLOT_W-1:0] o_best_slot,
    output logic [TILE_W-1:0] o_best_owner
);

    t_slot_entry       r_mem [CACHE_SLOTS];
    t_slot_entry       r_rdata;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx;
    logic [TICK_W-1:0] r_best_age;
    logic [SLOT_W-1:0] r_best_slot;
    logic [TILE_W-1:0] r_best_owner;
    logic [TICK_W-1:0] w_age;
    logic              w_take;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.en) begin
            r_rdata <= r_mem[i_scan.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_scan.en;
        end
        r_cmp_idx <= i_scan.addr;
    end

    // Slot zero always seeds the search, so all-zero ages pick slot zero.
    assign w_age  = i_now - r_rdata.seen;
    assign w_take = r_cmp_vld && ((r_cmp_idx == '0) || (w_age > r_best_age));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_age   <= w_age;
            r_best_slot  <= r_cmp_idx;
            r_best_owner <= r_rdata.owner;
        end
    end

    assign o_best_slot  = r_best_slot;
    assign o_best_owner = r_best_owner;

endmodule

FILE: hdl/tile_slot_cache_lru_unit.sv
// Top level of the tile slot cache with timestamp LRU replacement.
//
// After reset the block sweeps the tile map invalid, one entry per cycle, with
// busy high. A request is taken when start is high and busy is low; busy then
// stays high until the result word is shown. A hit or a miss into a free slot
// is resolved in the lookup state, and o_done is registered from it. A miss
// with every slot occupied scans the slot memory one slot per cycle through its
// single read port, then passes through the evict and fill states. The result
// word is shown for exactly one cycle with o_done and must be taken then.
module tile_slot_cache_lru_unit
    import tslc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    t_res              r_res;
    t_res              n_res;
    logic              r_done;
    logic [TILE_W-1:0] r_clr;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;

    logic              w_map_re;
    logic [TILE_W-1:0] w_map_raddr;
    logic              w_map_we;
    logic [TILE_W-1:0] w_map_waddr;
    t_map_entry        w_map_wdata;
    t_map_entry        w_map_rdata;
    t_slot_wr          w_slot_wr;
    t_scan_ctl         w_scan;
    logic [SLOT_W-1:0] w_best_slot;
    logic [TILE_W-1:0] w_best_owner;
    logic              w_full;
    logic              w_scan_done;
    logic              w_fill_inc;
    logic              w_res_load;
    logic              w_res_hit;
    logic              w_res_evict;
    logic [SLOT_W-1:0] w_res_slot;
    logic [TILE_W-1:0] w_req_tile;

    logic [HALF_W-1:0] w_base;
    logic [HALF_W-1:0] w_upper_idx;
    logic [HALF_W-1:0] w_lower_idx;

    assign w_req_tile  = TILE_W'(r_req.tile_id);
    assign w_full      = (r_fill == FILL_W'(CACHE_SLOTS));
    assign w_scan_done = (r_idx == FILL_W'(CACHE_SLOTS));

    tslc_map_store u_map (
        .i_clk   (i_clk),
        .i_re    (w_map_re),
        .i_raddr (w_map_raddr),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .o_rdata (w_map_rdata)
    );

    tslc_slot_store u_slot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_slot_wr),
        .i_scan       (w_scan),
        .i_now        (r_req.now_tick),
        .o_best_slot  (w_best_slot),
        .o_best_owner (w_best_owner)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == TILE_W'(LOGICAL_TILES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_map_rdata.valid || !w_full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: n_state = S_FILL;
            S_FILL:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        w_map_re    = 1'b0;
        w_map_raddr = TILE_W'(i_req.tile_id);
        w_map_we    = 1'b0;
        w_map_waddr = w_req_tile;
        w_map_wdata = '0;
        w_slot_wr   = '0;
        w_scan      = '0;
        w_fill_inc  = 1'b0;
        w_res_load  = 1'b0;
        w_res_hit   = 1'b0;
        w_res_evict = 1'b0;
        w_res_slot  = w_best_slot;
        unique case (r_state)
            S_CLEAR: begin
                w_map_we    = 1'b1;
                w_map_waddr = r_clr;
            end
            S_IDLE: begin
                w_map_re = start;
            end
            S_LOOK: begin
                if (w_map_rdata.valid) begin
                    w_res_hit  = 1'b1;
                    w_res_slot = w_map_rdata.slot;
                    w_res_load = 1'b1;
                end else if (!w_full) begin
                    w_res_slot  = r_fill[SLOT_W-1:0];
                    w_map_we    = 1'b1;
                    w_map_wdata = '{valid: 1'b1, slot: r_fill[SLOT_W-1:0]};
                    w_fill_inc  = 1'b1;
                    w_res_load  = 1'b1;
                end
                w_slot_wr.en   = w_res_load;
                w_slot_wr.addr = w_res_slot;
                w_slot_wr.data = '{owner: w_req_tile, seen: r_req.now_tick};
            end
            S_SCAN: begin
                w_scan.en   = !w_scan_done;
                w_scan.addr = r_idx[SLOT_W-1:0];
            end
            S_EVICT: begin
                w_map_we    = 1'b1;
                w_map_waddr = w_best_owner;
            end
            S_FILL: begin
                w_map_we       = 1'b1;
                w_map_wdata    = '{valid: 1'b1, slot: w_best_slot};
                w_slot_wr.en   = 1'b1;
                w_slot_wr.addr = w_best_slot;
                w_slot_wr.data = '{owner: w_req_tile, seen: r_req.now_tick};
                w_res_evict    = 1'b1;
                w_res_load     = 1'b1;
            end
            default: begin
                w_map_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_base      = HALF_W'(w_res_slot) << SUB_SHIFT;
        w_upper_idx = HALF_W'(r_req.col) + HALF_W'(r_req.row) * HALF_W'(MAP_WIDTH);
        w_lower_idx = HALF_W'(r_req.col)
                    + (HALF_W'(r_req.row) + HALF_W'(1)) * HALF_W'(MAP_WIDTH);
        n_res.hit          = w_res_hit;
        n_res.slot         = 8'(w_res_slot);
        n_res.base_tile    = w_base[INDEX_W-1:0];
        n_res.evicted      = w_res_evict;
        n_res.evicted_tile = w_res_evict ? 10'(w_best_owner) : 10'd0;
        n_res.upper_index  = w_upper_idx[INDEX_W-1:0];
        n_res.lower_index  = w_lower_idx[INDEX_W-1:0];
        n_res.upper_word   = {w_base + HALF_W'(1), w_base};
        n_res.lower_word   = {w_base + HALF_W'(3), w_base + HALF_W'(2)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_res_load;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + TILE_W'(1);
            end
            if (w_fill_inc) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (r_state == S_SCAN && !w_scan_done) begin
                r_idx <= r_idx + FILL_W'(1);
            end else if (r_state != S_SCAN) begin
                r_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        if (w_res_load) begin
            r_res <= n_res;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word shown while busy");

    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> w_full)
        else $error("eviction scan with a free slot left");

    a_look_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> $past(start && !busy))
        else $error("lookup without an accepted request");

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.evicted) |-> !o_res.hit)
        else $error("eviction reported on a hit");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill_inc |-> !w_full)
        else $error("fill count overflow");

endmodule
